// File: sv/dlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlc_pkg: shared definitions for the dark line centroid block
// Widths, reset values, register indexes and sizing functions.
// ----------------------------------------------------------------------------
package dlc_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int INTENSITY_W = 8;
  localparam int POS_W       = 18;
  localparam int SIZE_W      = 11;
  localparam int THR_W       = 9;
  localparam int SIZE_EXT_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam int FRAC_SHIFT  = 7;
  localparam int QUEUE_DEPTH = 2;

  localparam int POS_POS_LIM = 2 ** (POS_W - 1) - 1;
  localparam int POS_NEG_LIM = 2 ** (POS_W - 1);

  localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = SIZE_W'(160);
  localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = SIZE_W'(120);
  localparam logic [THR_W-1:0]  RST_THRESHOLD    = THR_W'(64);
  localparam logic [SIZE_W-1:0] RST_BAND_ROWS    = SIZE_W'(10);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DARK_THRESHOLD = 2'd2,
    REG_BAND_ROWS      = 2'd3
  } cfg_reg_t;

  function automatic int col_bits(int max_width);
    return (max_width > 1) ? $clog2(max_width) : 1;
  endfunction

  function automatic int row_bits(int max_height);
    return (max_height > 1) ? $clog2(max_height) : 1;
  endfunction

  function automatic int sum_bits(int max_width, int max_height);
    return 2 * col_bits(max_width) + row_bits(max_height) + 2;
  endfunction

  function automatic int cnt_bits(int max_width, int max_height);
    return col_bits(max_width) + row_bits(max_height) + 1;
  endfunction

endpackage

// File: sv/dlc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlc_if: channel interfaces of the dark line centroid block
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface dlc_pix_if;
  import dlc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [INTENSITY_W-1:0] intensity;
  logic                   first_pixel;
  modport source (output valid, output intensity, output first_pixel, input ready);
  modport sink (input valid, input intensity, input first_pixel, output ready);
endinterface

interface dlc_res_if;
  import dlc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] position;
  logic                    found;
  modport source (output valid, output position, output found, input ready);
  modport sink (input valid, input position, input found, output ready);
endinterface

interface dlc_cfg_if;
  import dlc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/dlc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlc_queue: short frame summary queue
// Holds finished frame sums between the pixel front and the divider back.
// ----------------------------------------------------------------------------
module dlc_queue #(
  parameter int DATA_W = 53,
  parameter int DEPTH  = dlc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              empty
);
  import dlc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    fill_nxt   = fill_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

// File: sv/dlc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlc_front: pixel front end
// Holds the configuration, tracks column and row, classifies dark pixels
// in the bottom band and accumulates their offset sum and count.
// ----------------------------------------------------------------------------
module dlc_front #(
  parameter int MAX_WIDTH  = dlc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dlc_pkg::DEF_MAX_HEIGHT,
  localparam int SUM_W = dlc_pkg::sum_bits(MAX_WIDTH, MAX_HEIGHT),
  localparam int CNT_W = dlc_pkg::cnt_bits(MAX_WIDTH, MAX_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst_n,
  dlc_pix_if.sink          pix,
  dlc_cfg_if.sink          cfg,
  input  logic             q_full,
  output logic             push,
  output logic [SUM_W-1:0] push_sum,
  output logic [CNT_W-1:0] push_cnt
);
  import dlc_pkg::*;

  localparam int CW = col_bits(MAX_WIDTH);
  localparam int RW = row_bits(MAX_HEIGHT);

  logic [SIZE_W-1:0] width_r, height_r, band_r;
  logic [THR_W-1:0]  thr_r;

  logic [CW-1:0]    col_r, col_nxt, col_cur;
  logic [RW-1:0]    row_r, row_nxt, row_cur;
  logic [SUM_W-1:0] sum_r, sum_nxt, sum_cur, acc_sum, term;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_cur, acc_cnt;

  logic [SIZE_EXT_W-1:0] w_raw, h_raw, b_raw, w_eff, h_eff, band_eff, band_start;
  logic accept, dark, hit, row_end, frame_end;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_FRAME_WIDTH;
      height_r <= RST_FRAME_HEIGHT;
      thr_r    <= RST_THRESHOLD;
      band_r   <= RST_BAND_ROWS;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_FRAME_WIDTH:    width_r  <= cfg.data;
        REG_FRAME_HEIGHT:   height_r <= cfg.data;
        REG_DARK_THRESHOLD: thr_r    <= cfg.data[THR_W-1:0];
        REG_BAND_ROWS:      band_r   <= cfg.data;
        default:            width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    w_raw = SIZE_EXT_W'(width_r);
    h_raw = SIZE_EXT_W'(height_r);
    b_raw = SIZE_EXT_W'(band_r);
    if (w_raw == '0) begin
      w_eff = SIZE_EXT_W'(1);
    end else if (w_raw > SIZE_EXT_W'(MAX_WIDTH)) begin
      w_eff = SIZE_EXT_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw == '0) begin
      h_eff = SIZE_EXT_W'(1);
    end else if (h_raw > SIZE_EXT_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_EXT_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    band_eff   = (b_raw > h_eff) ? h_eff : b_raw;
    band_start = h_eff - band_eff;
  end

  always_comb begin
    col_cur = pix.first_pixel ? '0 : col_r;
    row_cur = pix.first_pixel ? '0 : row_r;
    sum_cur = pix.first_pixel ? '0 : sum_r;
    cnt_cur = pix.first_pixel ? '0 : cnt_r;

    dark = ({1'b0, pix.intensity} < thr_r);
    hit  = (band_eff != '0) && (SIZE_EXT_W'(row_cur) >= band_start) && dark;
    term = SUM_W'({col_cur, 1'b0}) - SUM_W'(w_eff);

    acc_sum = hit ? sum_cur + term : sum_cur;
    acc_cnt = cnt_cur + CNT_W'(hit);

    row_end   = (SIZE_EXT_W'(col_cur) + SIZE_EXT_W'(1)) >= w_eff;
    frame_end = row_end && ((SIZE_EXT_W'(row_cur) + SIZE_EXT_W'(1)) >= h_eff);

    col_nxt = col_r;
    row_nxt = row_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = acc_sum;
        cnt_nxt = acc_cnt;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = row_cur + RW'(1);
        end else begin
          col_nxt = col_cur + CW'(1);
          row_nxt = row_cur;
        end
      end
    end
  end

  assign pix.ready = !q_full;
  assign accept    = pix.valid && pix.ready;
  assign push      = accept && frame_end;
  assign push_sum  = acc_sum;
  assign push_cnt  = acc_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: sv/dlc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlc_back: centroid divider back end
// Takes one frame summary at a time, divides the scaled offset sum by the
// dark pixel count one quotient bit per cycle, saturates and presents the
// result in an output register.
// ----------------------------------------------------------------------------
module dlc_back #(
  parameter int MAX_WIDTH  = dlc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dlc_pkg::DEF_MAX_HEIGHT,
  localparam int SUM_W = dlc_pkg::sum_bits(MAX_WIDTH, MAX_HEIGHT),
  localparam int CNT_W = dlc_pkg::cnt_bits(MAX_WIDTH, MAX_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  logic [SUM_W-1:0] q_sum,
  input  logic [CNT_W-1:0] q_cnt,
  output logic             pop,
  dlc_res_if.source        res
);
  import dlc_pkg::*;

  localparam int DIVD_W = SUM_W + FRAC_SHIFT;
  localparam int STEP_W = $clog2(DIVD_W + 1);
  localparam int EXT_W  = DIVD_W + POS_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              neg_r, neg_nxt;
  logic              found_r, found_nxt;

  logic                    res_valid_r, res_valid_nxt;
  logic signed [POS_W-1:0] res_pos_r, res_pos_nxt;
  logic                    res_found_r, res_found_nxt;

  logic [SUM_W-1:0] mag;
  logic [CNT_W:0]   trial, diff;
  logic             ge;
  logic [EXT_W-1:0] qx, lim;
  logic [POS_W-1:0] mag_sat, pos_val;
  logic             load;

  always_comb begin
    mag   = q_sum[SUM_W-1] ? SUM_W'(-q_sum) : q_sum;
    trial = {rem_r, quo_r[DIVD_W-1]};
    diff  = trial - {1'b0, div_r};
    ge    = (trial >= {1'b0, div_r});

    qx      = EXT_W'(quo_r);
    lim     = neg_r ? EXT_W'(POS_NEG_LIM) : EXT_W'(POS_POS_LIM);
    mag_sat = (qx > lim) ? lim[POS_W-1:0] : qx[POS_W-1:0];
    pos_val = neg_r ? POS_W'(-mag_sat) : mag_sat;
  end

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    found_nxt = found_r;
    pop       = 1'b0;
    load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          neg_nxt   = q_sum[SUM_W-1];
          div_nxt   = q_cnt;
          rem_nxt   = '0;
          step_nxt  = STEP_W'(DIVD_W);
          found_nxt = (q_cnt != '0);
          if (q_cnt != '0) begin
            quo_nxt   = {mag, {FRAC_SHIFT{1'b0}}};
            state_nxt = ST_DIV;
          end else begin
            quo_nxt   = '0;
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        quo_nxt  = {quo_r[DIVD_W-2:0], ge};
        rem_nxt  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid_r || res.ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    res_pos_nxt   = res_pos_r;
    res_found_nxt = res_found_r;
    if (load) begin
      res_valid_nxt = 1'b1;
      res_pos_nxt   = pos_val;
      res_found_nxt = found_r;
    end else if (res.ready) begin
      res_valid_nxt = 1'b0;
    end
  end

  assign res.valid    = res_valid_r;
  assign res.position = res_pos_r;
  assign res.found    = res_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r       <= quo_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    step_r      <= step_nxt;
    neg_r       <= neg_nxt;
    found_r     <= found_nxt;
    res_pos_r   <= res_pos_nxt;
    res_found_r <= res_found_nxt;
  end

endmodule

// File: sv/dark_line_centroid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dark_line_centroid: dark line centroid over a raster pixel stream
// Pixels enter on in_pix, one beat per pixel in raster order, with
// first_pixel marking the top-left pixel. The front end takes one pixel
// per cycle while the queue has room and keeps column, row, offset sum
// and dark count for the bottom band. On the last pixel of a frame it
// pushes the frame summary into a two-entry queue, and the back end
// divides it with a restoring divider, one quotient bit per cycle.
// Each result beat on out_res carries the mean offset (7 fractional bits)
// and the found flag. Short frames can fill the queue while the divider
// runs, and in_pix.ready then drops until the divider frees an entry.
// Registers are written on cfg_wr, which is always ready; write them only
// while no frame is in progress.
// Reset loads the register defaults (160, 120, 64, 10) and clears the
// counters, sums, queue and output. A stalled out_res holds its beat
// while the divider and queue keep working behind it.
// ----------------------------------------------------------------------------
module dark_line_centroid #(
  parameter int MAX_WIDTH  = dlc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dlc_pkg::DEF_MAX_HEIGHT
) (
  input  logic      clk,
  input  logic      rst_n,
  dlc_pix_if.sink   in_pix,
  dlc_res_if.source out_res,
  dlc_cfg_if.sink   cfg_wr
);
  import dlc_pkg::*;

  localparam int SUM_W = sum_bits(MAX_WIDTH, MAX_HEIGHT);
  localparam int CNT_W = cnt_bits(MAX_WIDTH, MAX_HEIGHT);
  localparam int ENT_W = SUM_W + CNT_W;

  logic             push, pop, q_full, q_empty;
  logic [SUM_W-1:0] push_sum;
  logic [CNT_W-1:0] push_cnt;
  logic [ENT_W-1:0] pop_data;

  dlc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix      (in_pix),
    .cfg      (cfg_wr),
    .q_full   (q_full),
    .push     (push),
    .push_sum (push_sum),
    .push_cnt (push_cnt)
  );

  dlc_queue #(
    .DATA_W (ENT_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_sum, push_cnt}),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  dlc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_sum   (pop_data[ENT_W-1:CNT_W]),
    .q_cnt   (pop_data[CNT_W-1:0]),
    .pop     (pop),
    .res     (out_res)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the dark line centroid block
// A queue-fed driver streams pixels into in_pix, and a monitor checks every
// beat on out_res against a frame tracker kept in the testbench. The tracker
// follows column, row, offset sum and dark count per pixel, and it queues the
// expected centroid when a frame closes. A short directed run covers the
// field extremes and the corner cases: band clamping, threshold limits, zero
// sizes, restarts and a resize in mid frame. Frames resized in mid frame
// reach both position limits and the height clamp. Random phases with small
// frames, broken frames and random idling on both sides follow. The register
// file is reprogrammed only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import dlc_pkg::*;

  typedef struct packed {
    logic [INTENSITY_W-1:0] intensity;
    logic                   first_pixel;
  } pixel_t;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic                    found;
  } centroid_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dlc_pix_if pix ();
  dlc_res_if res ();
  dlc_cfg_if cfg ();

  dark_line_centroid i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix),
    .out_res (res),
    .cfg_wr  (cfg)
  );

  always #2 clk = ~clk;

  pixel_t    pixel_q[$];
  centroid_t centroid_q[$];
  int        pixels_pushed = 0;
  int        pixels_accepted = 0;
  int        errors = 0;
  bit        sender_fast = 1'b0;
  bit        receiver_fast = 1'b0;
  bit        long_hold = 1'b0;
  int        pix_gap = 0;
  int        res_gap = 0;
  pixel_t    pix_next;
  centroid_t res_exp;

  logic [SIZE_W-1:0] fw_reg = RST_FRAME_WIDTH;
  logic [SIZE_W-1:0] fh_reg = RST_FRAME_HEIGHT;
  logic [THR_W-1:0]  thr_reg = RST_THRESHOLD;
  logic [SIZE_W-1:0] band_reg = RST_BAND_ROWS;
  int unsigned       col_cnt = 0;
  int unsigned       row_cnt = 0;
  int unsigned       dark_cnt = 0;
  longint            off_sum = 0;

  function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic void clear_frame();
    col_cnt = 0;
    row_cnt = 0;
    dark_cnt = 0;
    off_sum = 0;
  endfunction

  // Advances the frame tracker by one accepted pixel.
  function automatic void centroid_step(logic [INTENSITY_W-1:0] v, logic first);
    int unsigned w;
    int unsigned h;
    int unsigned band;
    longint      mag;
    longint      q;
    centroid_t   r;
    w = clamp_dim(fw_reg, DEF_MAX_WIDTH);
    h = clamp_dim(fh_reg, DEF_MAX_HEIGHT);
    band = (band_reg > h) ? h : band_reg;
    if (first) clear_frame();
    if (band > 0 && row_cnt >= h - band && v < thr_reg) begin
      off_sum += 2 * longint'(col_cnt) - longint'(w);
      dark_cnt++;
    end
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        r.position = '0;
        r.found = 1'b0;
        if (dark_cnt != 0) begin
          mag = (off_sum < 0) ? -off_sum : off_sum;
          q = (mag * 128) / longint'(dark_cnt);
          if (q > (longint'(1) << 20)) q = longint'(1) << 20;
          if (off_sum < 0) q = -q;
          if (q > POS_POS_LIM) q = POS_POS_LIM;
          if (q < -POS_NEG_LIM) q = -POS_NEG_LIM;
          r.position = q[POS_W-1:0];
          r.found = 1'b1;
        end
        centroid_q.push_back(r);
        clear_frame();
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end
  endfunction

  function automatic logic [INTENSITY_W-1:0] pick_intensity();
    int v;
    case ($urandom_range(0, 3))
      0: v = int'(thr_reg) + int'($urandom_range(0, 3)) - 2;
      1: v = $urandom_range(0, 1) ? 255 : 0;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[INTENSITY_W-1:0];
  endfunction

  task automatic push_pixel(logic [INTENSITY_W-1:0] v, logic first);
    pixel_t p;
    p.intensity = v;
    p.first_pixel = first;
    pixel_q.push_back(p);
    pixels_pushed++;
  endtask

  task automatic wait_idle();
    while (pixels_accepted != pixels_pushed || centroid_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic program_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                               logic [CFG_DATA_W-1:0] t, logic [CFG_DATA_W-1:0] b);
    logic [CFG_DATA_W-1:0] vals[4];
    cfg_reg_t              idx;
    vals = '{w, h, t, b};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_t'(i);
      cfg.valid <= 1'b1;
      cfg.index <= idx;
      cfg.data <= vals[i];
      @(posedge clk);
      while (!cfg.ready) @(posedge clk);
      case (idx)
        REG_FRAME_WIDTH:    fw_reg = vals[i];
        REG_FRAME_HEIGHT:   fh_reg = vals[i];
        REG_DARK_THRESHOLD: thr_reg = vals[i][THR_W-1:0];
        REG_BAND_ROWS:      band_reg = vals[i];
        default: ;
      endcase
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic push_random_frame();
    int   npix;
    int   cut;
    int   mark;
    logic lead;
    npix = clamp_dim(fw_reg, DEF_MAX_WIDTH) * clamp_dim(fh_reg, DEF_MAX_HEIGHT);
    cut = npix;
    mark = -1;
    lead = 1'b1;
    case ($urandom_range(0, 9))
      7: cut = $urandom_range(1, npix);
      8: lead = 1'b0;
      9: mark = $urandom_range(0, npix - 1);
      default: ;
    endcase
    for (int p = 0; p < cut; p++) push_pixel(pick_intensity(), (p == 0 && lead) || p == mark);
  endtask

  task automatic push_single_dark(int npix, int target);
    for (int p = 0; p < npix; p++) push_pixel((p == target) ? 8'd0 : 8'd255, p == 0);
  endtask

  task automatic random_phase();
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    logic [CFG_DATA_W-1:0] t;
    logic [CFG_DATA_W-1:0] b;
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = CFG_DATA_W'($urandom_range(9, 16));
      default: w = CFG_DATA_W'($urandom_range(1, 8));
    endcase
    case ($urandom_range(0, 9))
      0: h = '0;
      1: h = CFG_DATA_W'($urandom_range(7, 10));
      default: h = CFG_DATA_W'($urandom_range(1, 6));
    endcase
    case ($urandom_range(0, 9))
      0: t = '0;
      1: t = CFG_DATA_W'(256);
      2: t = CFG_DATA_W'($urandom_range(257, 2047));
      default: t = CFG_DATA_W'($urandom_range(1, 255));
    endcase
    case ($urandom_range(0, 9))
      0: b = '0;
      1: b = CFG_DATA_W'($urandom_range(11, 2047));
      default: b = CFG_DATA_W'($urandom_range(1, 10));
    endcase
    program_frame(w, h, t, b);
    sender_fast <= ($urandom_range(0, 3) == 0);
    receiver_fast <= ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(2, 6)) push_random_frame();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pix.valid <= 1'b0;
      pix_gap = 0;
    end else begin
      if (pix.valid && pix.ready) begin
        centroid_step(pix.intensity, pix.first_pixel);
        pixels_accepted++;
      end
      if (!pix.valid || pix.ready) begin
        if (pix_gap > 0) begin
          pix_gap--;
          pix.valid <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          pix_next = pixel_q.pop_front();
          pix.valid <= 1'b1;
          pix.intensity <= pix_next.intensity;
          pix.first_pixel <= pix_next.first_pixel;
          pix_gap = sender_fast ? 0 : $urandom_range(0, 13);
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      res.ready <= 1'b0;
      res_gap = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (centroid_q.size() == 0) begin
          $display("%0t: result beat with none expected, got position %0d found %0b",
                   $time, res.position, res.found);
          errors++;
        end else begin
          res_exp = centroid_q.pop_front();
          if (res.position !== res_exp.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, res_exp.position, res.position);
            errors++;
          end
          if (res.found !== res_exp.found) begin
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, res_exp.found, res.found);
            errors++;
          end
        end
        res_gap = receiver_fast ? 0 : $urandom_range(0, 13);
      end
      if (long_hold || res_gap > 0) begin
        res.ready <= 1'b0;
        if (!long_hold) res_gap--;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Long receiver stall so that the frame summary queue fills and in_pix backs up.
  initial begin
    wait (long_hold);
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int base;
    pix.valid = 1'b0;
    pix.intensity = '0;
    pix.first_pixel = 1'b0;
    res.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_FRAME_WIDTH;
    cfg.data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_frame(4, 2, 64, 10);
    push_pixel(0, 1);
    push_pixel(255, 0);
    push_pixel(63, 0);
    push_pixel(64, 0);
    push_pixel(1, 0);
    push_pixel(200, 0);
    push_pixel(10, 0);
    push_pixel(255, 0);
    push_pixel(5, 1);
    push_pixel(6, 0);
    push_pixel(7, 0);
    for (int p = 0; p < 8; p++) push_pixel(100, p == 0);
    program_frame(2, 2, 0, 1);
    for (int p = 0; p < 4; p++) push_pixel(0, p == 0);
    program_frame(2, 2, 2047, 0);
    for (int p = 0; p < 4; p++) push_pixel(0, p == 0);
    program_frame(0, 0, 256, 2047);
    push_pixel(255, 1);
    push_pixel(0, 0);
    program_frame(4, 3, 128, 3);
    for (int p = 0; p < 5; p++) push_pixel(pick_intensity(), p == 0);
    program_frame(2, 2, 128, 2);
    for (int p = 0; p < 5; p++) push_pixel(pick_intensity(), 1'b0);

    program_frame(2047, 0, 1, 2047);
    push_pixel(0, 1);
    program_frame(1, 0, 1, 2047);
    push_pixel(255, 0);
    program_frame(2047, 0, 1, 2047);
    push_single_dark(520, -1);
    program_frame(1, 0, 1, 2047);
    push_pixel(0, 0);
    program_frame(1, 2047, 128, 1000);
    for (int p = 0; p < 30; p++) push_pixel(0, p == 0);
    program_frame(1, 1, 128, 1000);
    push_pixel(255, 0);

    program_frame(1, 1, 128, 1);
    sender_fast <= 1'b1;
    long_hold <= 1'b1;
    for (int p = 0; p < 40; p++) push_pixel(pick_intensity(), $urandom_range(0, 1));
    wait_idle();
    sender_fast <= 1'b0;

    base = pixels_pushed;
    while (pixels_pushed < base + 900) random_phase();

    wait_idle();
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
